### rtl/core/two_input_fuzzy_inference_assert.svh
// Assertion macros for the fuzzy inference core.
// Include from a module body that has i_clk and i_rst_n; no other dependencies.
`ifndef TWO_INPUT_FUZZY_INFERENCE_ASSERT_SVH
`define TWO_INPUT_FUZZY_INFERENCE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TFI_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fuzzy inference check failed");
// next-cycle implication
`define TFI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fuzzy inference check failed");
`else
`define TFI_ASSERT_IMPLY(lbl, ante, cons)
`define TFI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### rtl/core/tfi_pkg.sv
// Shared widths, constants and register indexes of the fuzzy inference core.
// No dependencies.
package tfi_pkg;
    localparam int DW       = 16;          // data width
    localparam int FW       = 16;          // membership fraction bits
    localparam int MW       = FW + 1;      // membership width, one = 2^FW
    localparam int TERMW    = 2 * MW;      // strength product
    localparam int PW       = TERMW + 1;   // sum of products
    localparam int TWW      = MW + 2;      // sum of four strengths
    localparam int PRODW    = DW + PW;     // span times product sum
    localparam int NW       = PRODW + 2;   // rounded numerator
    localparam int MGW      = NW - FW - 1; // numerator over 2^(FW+1)
    localparam int MSTEPS   = FW / 2;      // membership divider stages
    localparam int QSTEPS   = DW / 2;      // final divider stages
    localparam int CFG_IDX_BITS = 3;

    localparam logic [MW-1:0] ONE = MW'(1) << FW;

    localparam logic [DW-1:0] RST_FIRST_LOW   = DW'(1000);
    localparam logic [DW-1:0] RST_FIRST_HIGH  = DW'(5000);
    localparam logic [DW-1:0] RST_SECOND_LOW  = DW'(100);
    localparam logic [DW-1:0] RST_SECOND_HIGH = DW'(600);
    localparam logic [DW-1:0] RST_OUT_LOW     = DW'(2000);
    localparam logic [DW-1:0] RST_OUT_HIGH    = DW'(7000);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FIRST_LOW   = 3'd0,
        CFG_FIRST_HIGH  = 3'd1,
        CFG_SECOND_LOW  = 3'd2,
        CFG_SECOND_HIGH = 3'd3,
        CFG_OUT_LOW     = 3'd4,
        CFG_OUT_HIGH    = 3'd5
    } t_cfg_idx;

    // how a membership is formed
    typedef enum logic [1:0] {
        MC_LIN  = 2'd0,
        MC_ZERO = 2'd1,
        MC_ONE  = 2'd2
    } t_mcode;
endpackage

### rtl/core/two_input_fuzzy_inference.sv
// Two-input, four-rule fuzzy inference core (Tsukamoto style), fully pipelined.
// Depends on tfi_pkg and two_input_fuzzy_inference_assert.svh.
//
// One transfer in, one transfer out. An item may enter every cycle while the
// output side does not stall. Most of the pipe is taken by two restoring
// dividers that retire two quotient bits per stage: eight stages for the four
// membership quotients, run in parallel, and eight for the final weighted
// average. Between them sit the rule minimum, the strength products, their
// sum, the span multiply and the rounding add. The whole pipe advances
// together; while a result waits on a stalled output, o_stall is raised and
// every stage holds. Configuration registers are read live by stages along
// the pipe, so write them only while the pipe is empty.
module two_input_fuzzy_inference (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tfi_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [tfi_pkg::DW-1:0]            i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [tfi_pkg::DW-1:0]            i_first_value,
    input  logic [tfi_pkg::DW-1:0]            i_second_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [tfi_pkg::DW-1:0]            o_crisp_result
);
    import tfi_pkg::*;

    `include "two_input_fuzzy_inference_assert.svh"

    // stage map: 0 setup, 1..8 membership divide, 9 rule min, 10 products,
    // 11 sum, 12 span multiply, 13 rounding, 14..21 final divide, 22 output
    localparam int S_MIN  = MSTEPS + 1;
    localparam int S_PROD = S_MIN + 1;
    localparam int S_SUM  = S_PROD + 1;
    localparam int S_MUL  = S_SUM + 1;
    localparam int S_RND  = S_MUL + 1;
    localparam int S_OUT  = S_RND + QSTEPS + 1;
    localparam int NSTG   = S_OUT + 1;

    // configuration registers
    logic [DW-1:0] r_first_low, r_first_high, r_second_low, r_second_high;
    logic [DW-1:0] r_out_low, r_out_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_low   <= RST_FIRST_LOW;
            r_first_high  <= RST_FIRST_HIGH;
            r_second_low  <= RST_SECOND_LOW;
            r_second_high <= RST_SECOND_HIGH;
            r_out_low     <= RST_OUT_LOW;
            r_out_high    <= RST_OUT_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_LOW:   r_first_low   <= i_cfg_data;
                CFG_FIRST_HIGH:  r_first_high  <= i_cfg_data;
                CFG_SECOND_LOW:  r_second_low  <= i_cfg_data;
                CFG_SECOND_HIGH: r_second_high <= i_cfg_data;
                CFG_OUT_LOW:     r_out_low     <= i_cfg_data;
                CFG_OUT_HIGH:    r_out_high    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // derived configuration; the user must keep it static while items are in flight, the block does not enforce it
    logic          neg;
    logic [DW-1:0] mag;
    logic [DW-1:0] div_w [4];
    assign neg      = r_out_high < r_out_low;
    assign mag      = neg ? (r_out_low - r_out_high) : (r_out_high - r_out_low);
    assign div_w[0] = r_first_high - r_first_low;
    assign div_w[1] = r_first_high - r_first_low;
    assign div_w[2] = r_second_high - r_second_low;
    assign div_w[3] = r_second_high - r_second_low;

    // global advance: hold everything while the output waits on a stall
    logic en;
    logic [NSTG-1:0] r_vld;
    assign en      = !r_vld[NSTG-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // ---------------- membership dividers ----------------
    // divider order: first falling, first rising, second falling, second rising
    logic [DW-1:0] r_mrem [MSTEPS+1][4];
    logic [FW-1:0] r_mq   [MSTEPS+1][4];
    t_mcode        r_mc   [MSTEPS+1][4];
    logic [DW-1:0] n_mrem [MSTEPS+1][4];
    logic [FW-1:0] n_mq   [MSTEPS+1][4];

    // setup loads the numerators, then two restoring steps per stage
    always_comb begin
        logic [DW-1:0] z, lo, hi;
        logic [DW:0]   r2;
        logic [DW-1:0] rem;
        logic [FW-1:0] q;
        for (int j = 0; j < 2; j++) begin
            z  = (j == 0) ? i_first_value : i_second_value;
            lo = (j == 0) ? r_first_low   : r_second_low;
            hi = (j == 0) ? r_first_high  : r_second_high;
            n_mrem[0][2*j]   = hi - z;
            n_mrem[0][2*j+1] = z - lo;
            n_mq[0][2*j]     = '0;
            n_mq[0][2*j+1]   = '0;
        end
        for (int s = 1; s <= MSTEPS; s++) begin
            for (int k = 0; k < 4; k++) begin
                rem = r_mrem[s-1][k];
                q   = r_mq[s-1][k];
                for (int b = 0; b < 2; b++) begin
                    r2 = {rem, 1'b0};
                    q  = {q[FW-2:0], 1'b0};
                    if (r2 >= {1'b0, div_w[k]}) begin
                        r2   = r2 - {1'b0, div_w[k]};
                        q[0] = 1'b1;
                    end
                    rem = r2[DW-1:0];
                end
                n_mrem[s][k] = rem;
                n_mq[s][k]   = q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s <= MSTEPS; s++) begin
                for (int k = 0; k < 4; k++) begin
                    r_mrem[s][k] <= n_mrem[s][k];
                    r_mq[s][k]   <= n_mq[s][k];
                end
            end
            // at or above high wins over at or below low
            for (int j = 0; j < 2; j++) begin
                if (((j == 0) ? i_first_value : i_second_value) >=
                    ((j == 0) ? r_first_high : r_second_high)) begin
                    r_mc[0][2*j]   <= MC_ZERO;
                    r_mc[0][2*j+1] <= MC_ONE;
                end else if (((j == 0) ? i_first_value : i_second_value) <=
                             ((j == 0) ? r_first_low : r_second_low)) begin
                    r_mc[0][2*j]   <= MC_ONE;
                    r_mc[0][2*j+1] <= MC_ZERO;
                end else begin
                    r_mc[0][2*j]   <= MC_LIN;
                    r_mc[0][2*j+1] <= MC_LIN;
                end
            end
            for (int s = 1; s <= MSTEPS; s++) begin
                r_mc[s] <= r_mc[s-1];
            end
        end
    end

    // ---------------- rules ----------------
    logic [MW-1:0] mem [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            case (r_mc[MSTEPS][k])
                MC_ZERO: mem[k] = '0;
                MC_ONE:  mem[k] = ONE;
                default: mem[k] = {1'b0, r_mq[MSTEPS][k]};
            endcase
        end
    end

    function automatic logic [MW-1:0] umin(input logic [MW-1:0] a, input logic [MW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    // strengths: rules 0,1 fall, rules 2,3 rise
    logic [MW-1:0]    r_w [4];
    logic [TERMW-1:0] r_term [4];
    logic [TWW-1:0]   r_tw_p, r_tw_s, r_tw_m;
    logic [PW-1:0]    r_p;
    logic [PRODW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w[0] <= umin(mem[0], mem[3]);
            r_w[1] <= umin(mem[0], mem[2]);
            r_w[2] <= umin(mem[1], mem[3]);
            r_w[3] <= umin(mem[1], mem[2]);
            // weighted consequent terms relative to out_low
            r_term[0] <= TERMW'(r_w[0]) * TERMW'(ONE - r_w[0]);
            r_term[1] <= TERMW'(r_w[1]) * TERMW'(ONE - r_w[1]);
            r_term[2] <= TERMW'(r_w[2]) * TERMW'(r_w[2]);
            r_term[3] <= TERMW'(r_w[3]) * TERMW'(r_w[3]);
            r_tw_p    <= TWW'(r_w[0]) + TWW'(r_w[1]) + TWW'(r_w[2]) + TWW'(r_w[3]);
            r_p       <= PW'(r_term[0]) + PW'(r_term[1]) + PW'(r_term[2])
                         + PW'(r_term[3]);
            r_tw_s    <= r_tw_p;
            r_prod    <= PRODW'(mag) * PRODW'(r_p);
            r_tw_m    <= r_tw_s;
        end
    end

    // ---------------- rounding and final divide ----------------
    // q = floor((2*mag*p + tw*2^FW - neg) / (tw*2^(FW+1)))
    logic [NW-1:0]  rnd_n;
    logic [MGW-1:0] rnd_m;
    assign rnd_n = NW'({r_prod, 1'b0}) + NW'({r_tw_m, {FW{1'b0}}}) - NW'(neg);
    assign rnd_m = rnd_n[NW-1:FW+1];

    logic [TWW-1:0] r_qrem [QSTEPS+1];
    logic [DW-1:0]  r_qlo  [QSTEPS+1];
    logic [DW-1:0]  r_qq   [QSTEPS+1];
    logic [TWW-1:0] r_qtw  [QSTEPS+1];
    logic [TWW-1:0] n_qrem [QSTEPS+1];
    logic [DW-1:0]  n_qlo  [QSTEPS+1];
    logic [DW-1:0]  n_qq   [QSTEPS+1];

    always_comb begin
        logic [TWW:0]   r2;
        logic [TWW-1:0] rem;
        logic [DW-1:0]  lo, q;
        n_qrem[0] = rnd_m[TWW+DW-1:DW];
        n_qlo[0]  = rnd_m[DW-1:0];
        n_qq[0]   = '0;
        for (int s = 1; s <= QSTEPS; s++) begin
            rem = r_qrem[s-1];
            lo  = r_qlo[s-1];
            q   = r_qq[s-1];
            for (int b = 0; b < 2; b++) begin
                r2 = {rem, lo[DW-1]};
                lo = {lo[DW-2:0], 1'b0};
                q  = {q[DW-2:0], 1'b0};
                if (r2 >= {1'b0, r_qtw[s-1]}) begin
                    r2   = r2 - {1'b0, r_qtw[s-1]};
                    q[0] = 1'b1;
                end
                rem = r2[TWW-1:0];
            end
            n_qrem[s] = rem;
            n_qlo[s]  = lo;
            n_qq[s]   = q;
        end
    end

    logic [DW-1:0] r_result;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s <= QSTEPS; s++) begin
                r_qrem[s] <= n_qrem[s];
                r_qlo[s]  <= n_qlo[s];
                r_qq[s]   <= n_qq[s];
            end
            r_qtw[0] <= r_tw_m;
            for (int s = 1; s <= QSTEPS; s++) begin
                r_qtw[s] <= r_qtw[s-1];
            end
            r_result <= neg ? (r_out_low - r_qq[QSTEPS]) : (r_out_low + r_qq[QSTEPS]);
        end
    end

    assign o_crisp_result = r_result;

    // ---------------- checks ----------------
    logic w_in_range;
    assign w_in_range = (r_w[0] <= ONE) && (r_w[1] <= ONE) && (r_w[2] <= ONE)
                        && (r_w[3] <= ONE);

    `TFI_ASSERT_IMPLY(a_stall_only_on_held_output, o_stall, o_valid && i_stall)
    `TFI_ASSERT_NEXT(a_accept_enters_pipe, i_valid && !o_stall, r_vld[0])
    `TFI_ASSERT_IMPLY(a_strength_in_range, r_vld[S_MIN], w_in_range)
endmodule

### sim/two_input_fuzzy_inference_chk.sv
// Result checker for the two-input fuzzy inference core: predicts each crisp result.
// Depends on tfi_pkg; watches the input, output and configuration ports of the core.
`timescale 1ns / 100ps
module two_input_fuzzy_inference_chk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tfi_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [tfi_pkg::DW-1:0]           i_cfg_data,
    input  logic                             i_valid,
    input  logic                             i_stall_in,
    input  logic [tfi_pkg::DW-1:0]           i_first_value,
    input  logic [tfi_pkg::DW-1:0]           i_second_value,
    input  logic                             i_valid_out,
    input  logic                             i_stall_out,
    input  logic [tfi_pkg::DW-1:0]           i_crisp_result,
    output int                               o_fail_count,
    output int                               o_pending
);
    import tfi_pkg::*;

    logic [DW-1:0] brk_first_lo, brk_first_hi, brk_second_lo, brk_second_hi;
    logic [DW-1:0] range_lo, range_hi;
    logic [DW-1:0] crisp_queue[$];

    // membership pair: falling and rising, Q1.FW, each truncated
    function automatic void membership(input logic [DW-1:0] z, lo, hi,
                                       output logic [63:0] fall, output logic [63:0] rise);
        logic [63:0] w;
        if (z >= hi) begin
            fall = 0;
            rise = 64'(ONE);
        end else if (z <= lo) begin
            fall = 64'(ONE);
            rise = 0;
        end else begin
            w = 64'(hi - lo);
            fall = (64'(hi - z) << FW) / w;
            rise = (64'(z - lo) << FW) / w;
        end
    endfunction

    function automatic logic [DW-1:0] defuzzify(input logic [DW-1:0] a, b);
        logic [63:0] d1, u1, d2, u2;
        logic [63:0] w[4];
        logic [127:0] psum, tw, num, den, q, mag;
        logic neg;
        membership(a, brk_first_lo, brk_first_hi, d1, u1);
        membership(b, brk_second_lo, brk_second_hi, d2, u2);
        w[0] = (d1 < u2) ? d1 : u2;
        w[1] = (d1 < d2) ? d1 : d2;
        w[2] = (u1 < u2) ? u1 : u2;
        w[3] = (u1 < d2) ? u1 : d2;
        psum = 0;
        tw = 0;
        for (int i = 0; i < 4; i++) begin
            psum += (i < 2) ? 128'(w[i]) * (128'(ONE) - w[i]) : 128'(w[i]) * w[i];
            tw += w[i];
        end
        if (tw == 0) return range_lo;
        neg = range_hi < range_lo;
        mag = neg ? 128'(range_lo - range_hi) : 128'(range_hi - range_lo);
        den = tw << FW;
        // round half up; for a negative span bias toward the upper end
        num = ((mag * psum) << 1) + den - (neg ? 128'd1 : 128'd0);
        q = num / (den << 1);
        return neg ? DW'(range_lo - q[DW-1:0]) : DW'(range_lo + q[DW-1:0]);
    endfunction

    always @(posedge i_clk) begin
        logic [DW-1:0] want;
        if (!i_rst_n) begin
            brk_first_lo  <= RST_FIRST_LOW;
            brk_first_hi  <= RST_FIRST_HIGH;
            brk_second_lo <= RST_SECOND_LOW;
            brk_second_hi <= RST_SECOND_HIGH;
            range_lo      <= RST_OUT_LOW;
            range_hi      <= RST_OUT_HIGH;
            o_fail_count  <= 0;
            o_pending     <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FIRST_LOW:   brk_first_lo  <= i_cfg_data;
                    CFG_FIRST_HIGH:  brk_first_hi  <= i_cfg_data;
                    CFG_SECOND_LOW:  brk_second_lo <= i_cfg_data;
                    CFG_SECOND_HIGH: brk_second_hi <= i_cfg_data;
                    CFG_OUT_LOW:     range_lo      <= i_cfg_data;
                    CFG_OUT_HIGH:    range_hi      <= i_cfg_data;
                    default: ;
                endcase
            end
            // results still owed by the core
            o_pending <= o_pending + ((i_valid && !i_stall_in) ? 1 : 0)
                         - ((i_valid_out && !i_stall_out) ? 1 : 0);
            if (i_valid && !i_stall_in)
                crisp_queue.insert(crisp_queue.size(),
                                   defuzzify(i_first_value, i_second_value));
            if (i_valid_out && !i_stall_out) begin
                if (crisp_queue.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected result transfer: %0d", i_crisp_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = crisp_queue.pop_front();
                    if (want !== i_crisp_result) begin
                        if (o_fail_count < 10)
                            $display("crisp_result mismatch: expected %0d, got %0d",
                                     want, i_crisp_result);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### sim/two_input_fuzzy_inference_tb.sv
// Testbench top for the two-input fuzzy inference core: stimulus, idling, verdict.
// Depends on tfi_pkg, two_input_fuzzy_inference and two_input_fuzzy_inference_chk.
`timescale 1ns / 100ps
module two_input_fuzzy_inference_tb;
    import tfi_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;   // extra wait after the last result is out

    logic                    i_clk = 0;
    logic                    i_rst_n = 0;
    logic                    i_cfg_we = 0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [DW-1:0]           i_cfg_data = '0;
    logic                    i_valid = 0;
    logic                    o_stall;
    logic [DW-1:0]           i_first_value = '0;
    logic [DW-1:0]           i_second_value = '0;
    logic                    o_valid;
    logic                    i_stall = 0;
    logic [DW-1:0]           o_crisp_result;

    int fail_count;
    int pending;
    int send_idle_pct = 29;
    int recv_idle_pct = 62;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    two_input_fuzzy_inference u_dut (.*);

    two_input_fuzzy_inference_chk u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_stall_in(o_stall), .i_first_value, .i_second_value,
        .i_valid_out(o_valid), .i_stall_out(i_stall), .i_crisp_result(o_crisp_result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver stall: re-rolled every edge
    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < recv_idle_pct);

    // watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // send one transfer; random idle cycles first, then hold until accepted
    task automatic send_item(input logic [DW-1:0] a, input logic [DW-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_first_value <= a;
        i_second_value <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // lower valid and wait for the pipe to empty
    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // raise the write enable and present one write; the caller drops it after the last write
    task automatic write_reg(input t_cfg_idx idx, input logic [DW-1:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_setting(input logic [DW-1:0] fl, fh, sl, sh, ol, oh);
        write_reg(CFG_FIRST_LOW, fl);
        write_reg(CFG_FIRST_HIGH, fh);
        write_reg(CFG_SECOND_LOW, sl);
        write_reg(CFG_SECOND_HIGH, sh);
        write_reg(CFG_OUT_LOW, ol);
        write_reg(CFG_OUT_HIGH, oh);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // pick a breakpoint, a value between the breakpoints, an extreme, or anything
    function automatic logic [DW-1:0] pick_value(input logic [DW-1:0] lo, hi);
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            2: return DW'($urandom_range(lo < hi ? lo : hi, lo < hi ? hi : lo));
            3: return $urandom_range(1) ? '0 : '1;
            default: return DW'($urandom);
        endcase
    endfunction

    function automatic logic [DW-1:0] rand_reg();
        return $urandom_range(3) == 0 ? DW'($urandom) : DW'($urandom_range(20000));
    endfunction

    task automatic random_items(input int count, input logic [DW-1:0] fl, fh, sl, sh);
        for (int i = 0; i < count; i++)
            send_item(pick_value(fl, fh), pick_value(sl, sh));
    endtask

    initial begin
        logic [DW-1:0] fl, fh, sl, sh;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset setting, field extremes and each membership region
        send_item('0, '0);
        send_item('1, '1);
        send_item('0, '1);
        send_item('1, '0);
        send_item(16'd1000, 16'd100);
        send_item(16'd5000, 16'd600);
        send_item(16'd3000, 16'd350);
        send_item(16'd1001, 16'd599);
        send_item(16'd4999, 16'd101);
        send_item(16'h5555, 16'hAAAA);
        send_item(16'hAAAA, 16'h5555);
        drain();

        // step membership (low equal high), low above high, falling output span
        load_setting(16'd2000, 16'd2000, 16'd700, 16'd300, 16'd9000, 16'd1000);
        send_item(16'd1999, 16'd500);
        send_item(16'd2000, 16'd300);
        send_item(16'd2001, 16'd700);
        send_item(16'd2000, 16'd200);
        send_item(16'd0, 16'd800);
        drain();

        // widest breakpoints and output range, both span directions
        load_setting('0, '1, '0, '1, '0, '1);
        send_item(16'd1, 16'd65534);
        send_item(16'd32768, 16'd32767);
        send_item(16'd12345, 16'd54321);
        drain();
        load_setting('0, '1, '0, '1, '1, '0);
        send_item(16'd32768, 16'd32767);
        send_item(16'd777, 16'd40000);
        send_item(16'd1, 16'd1);
        drain();

        // random phases: sender 29 / receiver 62, then swapped, then no idling
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 29 : 0;
            for (int s = 0; s < 5; s++) begin
                fl = rand_reg();
                fh = $urandom_range(4) == 0 ? rand_reg() : fl + DW'($urandom_range(30000));
                sl = rand_reg();
                sh = $urandom_range(4) == 0 ? rand_reg() : sl + DW'($urandom_range(30000));
                load_setting(fl, fh, sl, sh, rand_reg(), rand_reg());
                random_items(72, fl, fh, sl, sh);
                drain();
            end
        end

        drain();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
